// ===== hdl/mh64_pkg.sv =====
`default_nettype none

package mh64_pkg;

	// Multiplier constants, in the order the lanes use them
	localparam logic [31:0] MH_K [4] = '{32'hD6D018F5, 32'hA2AA033B, 32'h62992FC1, 32'h30BC5B29};
	localparam logic [1:0] KI_0 = 2'd0;
	localparam logic [1:0] KI_1 = 2'd1;
	localparam logic [1:0] KI_2 = 2'd2;
	localparam logic [1:0] KI_3 = 2'd3;

	localparam logic [31:0] SEED_RESET = 32'h0001_2513;

	// Working register indexes in the datapath
	localparam logic [2:0] RI_L0 = 3'd0;
	localparam logic [2:0] RI_L1 = 3'd1;
	localparam logic [2:0] RI_L2 = 3'd2;
	localparam logic [2:0] RI_L3 = 3'd3;
	localparam logic [2:0] RI_H  = 3'd4;
	localparam logic [2:0] RI_P  = 3'd5;
	localparam logic [2:0] RI_X  = 3'd6;
	localparam logic [2:0] RI_Y  = 3'd7;

	typedef enum logic [1:0] {MU_NONE, MU_LO, MU_HI} mul_op_t;

	typedef enum logic [2:0] {MS_REG, MS_SUM, MS_WORD, MS_PIECE, MS_SEED} mul_src_t;

	typedef enum logic [3:0] {
		AL_NOP, AL_INIT, AL_LANE, AL_ROTADD, AL_MOV, AL_XOR, AL_XROT,
		AL_ADD, AL_ADDR, AL_FOLDH, AL_ROT, AL_XSELF, AL_LOADP
	} alu_op_t;

	typedef enum logic [1:0] {PC_FULL, PC_W32, PC_W16, PC_W8} piece_t;

	typedef struct packed {
		logic      load;
		logic      load_first;
		mul_op_t   mul;
		mul_src_t  msrc;
		logic [2:0] ma;
		logic [2:0] mb;
		logic [1:0] ksel;
		alu_op_t   alu;
		logic [2:0] d;
		logic [2:0] b;
		logic [5:0] rot;
		piece_t    pc;
		logic [5:0] psh;
		logic      capture;
	} mh_cmd_t;

	function automatic logic [63:0] rotr64(input logic [63:0] x, input logic [5:0] r);
		logic [6:0] rl;
		rl = 7'd64 - {1'b0, r};
		return (x >> r) | (x << rl);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/mh64_dpath.sv =====
`default_nettype none

module mh64_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  mh64_pkg::mh_cmd_t cmd,
	input  logic [63:0]       data_word,
	input  logic [31:0]       message_length,
	input  logic              seed_we,
	input  logic [31:0]       seed_wdata,
	output logic [63:0]       hash_value
);
	import mh64_pkg::*;

	logic [63:0] l0_q, l1_q, l2_q, l3_q, h_q, p_q, x_q, y_q;
	logic [63:0] w_q, m_q, pp_q, out_q;
	logic [31:0] len_q, seed_q, hi_q, kq_q;

	logic [63:0] src_c, pp_c, piece_c, shw_c, ar_c, br_c, res_c;
	logic [31:0] k_c, hp_c;
	logic        wr_c;

	function automatic logic [63:0] pick(input logic [2:0] i, input logic [63:0] a0,
		input logic [63:0] a1, input logic [63:0] a2, input logic [63:0] a3,
		input logic [63:0] a4, input logic [63:0] a5, input logic [63:0] a6,
		input logic [63:0] a7);
		logic [63:0] v;
		unique case (i)
			RI_L0: v = a0;
			RI_L1: v = a1;
			RI_L2: v = a2;
			RI_L3: v = a3;
			RI_H:  v = a4;
			RI_P:  v = a5;
			RI_X:  v = a6;
			default: v = a7;
		endcase
		return v;
	endfunction

	// Select tail chunk from the held word
	always_comb begin
		shw_c = w_q >> cmd.psh;
		case (cmd.pc)
			PC_W32:  piece_c = {32'd0, w_q[31:0]};
			PC_W16:  piece_c = {48'd0, shw_c[15:0]};
			PC_W8:   piece_c = {56'd0, shw_c[7:0]};
			default: piece_c = w_q;
		endcase
	end

	// Multiplier operand and the low and high partial products
	always_comb begin
		case (cmd.msrc)
			MS_SUM:   src_c = pick(cmd.ma, l0_q, l1_q, l2_q, l3_q, h_q, p_q, x_q, y_q)
			                + pick(cmd.mb, l0_q, l1_q, l2_q, l3_q, h_q, p_q, x_q, y_q);
			MS_WORD:  src_c = w_q;
			MS_PIECE: src_c = piece_c;
			MS_SEED:  src_c = 64'(seed_q) + 64'(MH_K[KI_2]);
			default:  src_c = pick(cmd.ma, l0_q, l1_q, l2_q, l3_q, h_q, p_q, x_q, y_q);
		endcase
		k_c  = MH_K[cmd.ksel];
		pp_c = 64'(src_c[31:0]) * 64'(k_c);
		hp_c = hi_q * kq_q;
	end

	// Result of the update step
	always_comb begin
		ar_c  = pick(cmd.d, l0_q, l1_q, l2_q, l3_q, h_q, p_q, x_q, y_q);
		br_c  = pick(cmd.b, l0_q, l1_q, l2_q, l3_q, h_q, p_q, x_q, y_q);
		wr_c  = 1'b1;
		res_c = m_q;
		case (cmd.alu)
			AL_LANE:   res_c = rotr64(ar_c + m_q, 6'd29) + br_c;
			AL_ROTADD: res_c = rotr64(br_c + m_q, cmd.rot);
			AL_MOV:    res_c = m_q;
			AL_XOR:    res_c = ar_c ^ m_q;
			AL_XROT:   res_c = ar_c ^ (rotr64(m_q, cmd.rot) + br_c);
			AL_ADD:    res_c = ar_c + m_q;
			AL_ADDR:   res_c = ar_c + br_c;
			AL_FOLDH:  res_c = ar_c + (l0_q ^ l1_q);
			AL_ROT:    res_c = rotr64(br_c, cmd.rot);
			AL_XSELF:  res_c = br_c ^ rotr64(br_c, cmd.rot);
			AL_LOADP:  res_c = w_q;
			AL_INIT:   res_c = m_q + 64'(len_q);
			default:   wr_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l0_q <= '0; l1_q <= '0; l2_q <= '0; l3_q <= '0;
			h_q <= '0; p_q <= '0; x_q <= '0; y_q <= '0;
			w_q <= '0; m_q <= '0; pp_q <= '0; out_q <= '0;
			len_q <= '0; hi_q <= '0; kq_q <= '0;
			seed_q <= SEED_RESET;
		end else begin
			if (seed_we) begin
				seed_q <= seed_wdata;
			end
			// Capture the accepted beat
			if (cmd.load) begin
				w_q <= data_word;
			end
			if (cmd.load_first) begin
				len_q <= message_length;
			end
			// 64x32 multiply: MU_LO registers the low partial product and operands, MU_HI adds the high partial product
			if (cmd.mul == MU_LO) begin
				pp_q <= pp_c;
				hi_q <= src_c[63:32];
				kq_q <= k_c;
			end else if (cmd.mul == MU_HI) begin
				m_q <= pp_q + {hp_c, 32'd0};
			end
			// Write back
			if (cmd.alu == AL_INIT) begin
				l0_q <= res_c; l1_q <= res_c; l2_q <= res_c; l3_q <= res_c;
				h_q <= res_c;
			end else if (wr_c) begin
				unique case (cmd.d)
					RI_L0: l0_q <= res_c;
					RI_L1: l1_q <= res_c;
					RI_L2: l2_q <= res_c;
					RI_L3: l3_q <= res_c;
					RI_H:  h_q <= res_c;
					RI_P:  p_q <= res_c;
					RI_X:  x_q <= res_c;
					default: y_q <= res_c;
				endcase
			end
			// Finalized hash sits in the scratch register; the running hash stays intact
			if (cmd.capture) begin
				out_q <= x_q;
			end
		end
	end

	assign hash_value = out_q;

endmodule

`default_nettype wire

// ===== hdl/mh64_ctrl.sv =====
`default_nettype none

module mh64_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [31:0]       message_length,
	input  logic              first_word,
	input  logic              last_word,
	output logic              out_valid,
	input  logic              out_stall,
	output mh64_pkg::mh_cmd_t cmd
);
	import mh64_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INIT, ST_DECIDE, ST_BULK, ST_FOLD, ST_FOLDH,
		ST_LOADP, ST_PAIR, ST_MIX, ST_END, ST_FINAL, ST_OUT
	} state_t;

	typedef enum logic [1:0] {PH_BULK, PH_TAIL, PH_DONE} phase_t;

	localparam logic [2:0] FOLD_SA  [4] = '{RI_L0, RI_L1, RI_L0, RI_L1};
	localparam logic [2:0] FOLD_SB  [4] = '{RI_L3, RI_L2, RI_L2, RI_L3};
	localparam logic [2:0] FOLD_ADD [4] = '{RI_L1, RI_L0, RI_L3, RI_L2};
	localparam logic [2:0] FOLD_DST [4] = '{RI_L2, RI_L3, RI_L0, RI_L1};
	localparam logic [1:0] FOLD_KA  [4] = '{KI_0, KI_1, KI_0, KI_1};
	localparam logic [1:0] FOLD_KB  [4] = '{KI_1, KI_0, KI_1, KI_0};

	state_t      state_q;
	phase_t      phase_q;
	logic [4:0]  step_q;
	logic [1:0]  fj_q, lane_q, li_q;
	logic [31:0] len_q, taken_q;
	logic        last_q, fold_q, full_q, out_valid_q;
	logic [2:0]  rem_q, qb_q;

	logic        accept;
	logic [31:0] bulk_end, pos_rel;
	logic [32:0] pos8;
	logic        reach_end;
	logic [4:0]  t5, rt5;
	piece_t      mix_pc;
	logic [5:0]  mix_sh, mix_rot;
	logic [2:0]  rem_nx;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid & ~in_stall;
	assign out_valid = out_valid_q;

	// Position of this beat inside the message
	always_comb begin
		bulk_end  = {len_q[31:5], 5'd0};
		pos8      = {1'b0, taken_q} + 33'd8;
		reach_end = pos8 >= {1'b0, len_q};
		pos_rel   = taken_q - bulk_end;
		t5        = pos_rel[4:0];
		rt5       = len_q[4:0] - t5;
	end

	// Pick the next tail chunk
	always_comb begin
		mix_pc  = PC_FULL;
		mix_sh  = 6'd0;
		mix_rot = 6'd36;
		rem_nx  = 3'd0;
		if (!full_q) begin
			if (rem_q[2]) begin
				mix_pc  = PC_W32;
				mix_rot = 6'd15;
				rem_nx  = {1'b0, rem_q[1:0]};
			end else if (rem_q[1]) begin
				mix_pc  = PC_W16;
				mix_sh  = qb_q[2] ? 6'd32 : 6'd0;
				mix_rot = 6'd15;
				rem_nx  = {2'b00, rem_q[0]};
			end else begin
				mix_pc  = PC_W8;
				mix_sh  = (qb_q[2] ? 6'd32 : 6'd0) + (qb_q[1] ? 6'd16 : 6'd0);
				mix_rot = 6'd23;
			end
		end
	end

	// Drive the datapath
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load       = accept;
				cmd.load_first = accept & first_word;
			end
			ST_INIT: begin
				case (step_q)
					5'd0: begin cmd.mul = MU_LO; cmd.msrc = MS_SEED; cmd.ksel = KI_0; end
					5'd1: cmd.mul = MU_HI;
					default: cmd.alu = AL_INIT;
				endcase
			end
			ST_BULK: begin
				case (step_q)
					5'd0: begin cmd.mul = MU_LO; cmd.msrc = MS_WORD; cmd.ksel = li_q; end
					5'd1: cmd.mul = MU_HI;
					default: begin
						cmd.alu = AL_LANE;
						cmd.d   = {1'b0, li_q};
						cmd.b   = {1'b0, li_q + 2'd2};
					end
				endcase
			end
			ST_FOLD: begin
				case (step_q)
					5'd0: begin
						cmd.mul = MU_LO; cmd.msrc = MS_SUM;
						cmd.ma = FOLD_SA[fj_q]; cmd.mb = FOLD_SB[fj_q]; cmd.ksel = FOLD_KA[fj_q];
					end
					5'd1: cmd.mul = MU_HI;
					5'd2: begin
						cmd.alu = AL_ROTADD; cmd.d = RI_X; cmd.b = FOLD_ADD[fj_q]; cmd.rot = 6'd30;
					end
					5'd3: begin
						cmd.mul = MU_LO; cmd.msrc = MS_REG; cmd.ma = RI_X; cmd.ksel = FOLD_KB[fj_q];
					end
					5'd4: cmd.mul = MU_HI;
					default: begin cmd.alu = AL_XOR; cmd.d = FOLD_DST[fj_q]; end
				endcase
			end
			ST_FOLDH: begin
				cmd.alu = AL_FOLDH; cmd.d = RI_H;
			end
			ST_LOADP: begin
				cmd.alu = AL_LOADP; cmd.d = RI_P;
			end
			ST_PAIR: begin
				case (step_q)
					5'd0:  begin cmd.mul = MU_LO; cmd.ma = RI_P; cmd.ksel = KI_2; end
					5'd2:  begin cmd.alu = AL_ROTADD; cmd.d = RI_X; cmd.b = RI_H; cmd.rot = 6'd29; end
					5'd3:  begin cmd.mul = MU_LO; cmd.ma = RI_X; cmd.ksel = KI_3; end
					5'd5:  begin cmd.alu = AL_MOV; cmd.d = RI_X; end
					5'd6:  begin cmd.mul = MU_LO; cmd.msrc = MS_WORD; cmd.ksel = KI_2; end
					5'd8:  begin cmd.alu = AL_ROTADD; cmd.d = RI_Y; cmd.b = RI_H; cmd.rot = 6'd29; end
					5'd9:  begin cmd.mul = MU_LO; cmd.ma = RI_Y; cmd.ksel = KI_3; end
					5'd11: begin cmd.alu = AL_MOV; cmd.d = RI_Y; end
					5'd12: begin cmd.mul = MU_LO; cmd.ma = RI_X; cmd.ksel = KI_0; end
					5'd14: begin cmd.alu = AL_XROT; cmd.d = RI_X; cmd.b = RI_Y; cmd.rot = 6'd34; end
					5'd15: begin cmd.mul = MU_LO; cmd.ma = RI_Y; cmd.ksel = KI_3; end
					5'd17: begin cmd.alu = AL_XROT; cmd.d = RI_Y; cmd.b = RI_X; cmd.rot = 6'd34; end
					5'd18: begin cmd.alu = AL_ADDR; cmd.d = RI_H; cmd.b = RI_Y; end
					default: cmd.mul = MU_HI;
				endcase
			end
			ST_MIX: begin
				cmd.pc  = mix_pc;
				cmd.psh = mix_sh;
				case (step_q)
					5'd0: begin cmd.mul = MU_LO; cmd.msrc = MS_PIECE; cmd.ksel = KI_3; end
					5'd1: cmd.mul = MU_HI;
					5'd2: begin cmd.alu = AL_ADD; cmd.d = RI_H; end
					5'd3: begin cmd.alu = AL_ROT; cmd.d = RI_X; cmd.b = RI_H; cmd.rot = mix_rot; end
					5'd4: begin cmd.mul = MU_LO; cmd.ma = RI_X; cmd.ksel = KI_1; end
					5'd5: cmd.mul = MU_HI;
					default: begin cmd.alu = AL_XOR; cmd.d = RI_H; end
				endcase
			end
			// Finalize into the scratch register, leaving the running hash as it is
			ST_FINAL: begin
				case (step_q)
					5'd0: begin cmd.alu = AL_XSELF; cmd.d = RI_X; cmd.b = RI_H; cmd.rot = 6'd28; end
					5'd1: begin cmd.mul = MU_LO; cmd.ma = RI_X; cmd.ksel = KI_0; end
					5'd2: cmd.mul = MU_HI;
					5'd3: begin cmd.alu = AL_MOV; cmd.d = RI_X; end
					default: begin
						cmd.alu = AL_XSELF; cmd.d = RI_X; cmd.b = RI_X; cmd.rot = 6'd29;
					end
				endcase
			end
			ST_OUT: begin
				cmd.capture = ~out_valid_q | ~out_stall;
			end
			default: ;
		endcase
	end

	// Sequencer and beat bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_BULK;
			step_q      <= '0;
			fj_q        <= '0;
			lane_q      <= '0;
			li_q        <= '0;
			len_q       <= '0;
			taken_q     <= '0;
			last_q      <= 1'b0;
			fold_q      <= 1'b0;
			full_q      <= 1'b0;
			rem_q       <= '0;
			qb_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last_word;
						step_q <= '0;
						if (first_word) begin
							len_q   <= message_length;
							taken_q <= '0;
							lane_q  <= '0;
							if (message_length == 32'd0) begin
								phase_q <= PH_DONE;
							end else if (message_length >= 32'd32) begin
								phase_q <= PH_BULK;
							end else begin
								phase_q <= PH_TAIL;
							end
							state_q <= ST_INIT;
						end else begin
							state_q <= ST_DECIDE;
						end
					end
				end
				ST_INIT: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd2) begin
						step_q  <= '0;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					step_q <= '0;
					fj_q   <= '0;
					if (phase_q == PH_DONE || taken_q >= len_q) begin
						state_q <= ST_END;
					end else begin
						taken_q <= reach_end ? len_q : pos8[31:0];
						if (phase_q == PH_BULK && taken_q < bulk_end) begin
							li_q    <= lane_q;
							lane_q  <= lane_q + 2'd1;
							fold_q  <= pos8 >= {1'b0, bulk_end};
							if (reach_end) begin
								phase_q <= PH_DONE;
							end else if (pos8 >= {1'b0, bulk_end}) begin
								phase_q <= PH_TAIL;
							end
							state_q <= ST_BULK;
						end else begin
							phase_q <= reach_end ? PH_DONE : PH_TAIL;
							if (len_q[4] && t5 == 5'd0) begin
								state_q <= ST_LOADP;
							end else if (len_q[4] && t5 == 5'd8) begin
								state_q <= ST_PAIR;
							end else if (rt5 >= 5'd8) begin
								full_q  <= 1'b1;
								state_q <= ST_MIX;
							end else begin
								full_q  <= 1'b0;
								rem_q   <= rt5[2:0];
								qb_q    <= rt5[2:0];
								phase_q <= PH_DONE;
								state_q <= ST_MIX;
							end
						end
					end
				end
				ST_BULK: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd2) begin
						step_q  <= '0;
						state_q <= fold_q ? ST_FOLD : ST_END;
					end
				end
				ST_FOLD: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd5) begin
						step_q <= '0;
						fj_q   <= fj_q + 2'd1;
						if (fj_q == 2'd3) begin
							state_q <= ST_FOLDH;
						end
					end
				end
				ST_FOLDH: state_q <= ST_END;
				ST_LOADP: state_q <= ST_END;
				ST_PAIR: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd18) begin
						step_q  <= '0;
						state_q <= ST_END;
					end
				end
				ST_MIX: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd6) begin
						step_q <= '0;
						rem_q  <= rem_nx;
						if (full_q || rem_nx == 3'd0) begin
							state_q <= ST_END;
						end
					end
				end
				ST_END: begin
					step_q <= '0;
					if (last_q) begin
						phase_q <= PH_DONE;
						state_q <= ST_FINAL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FINAL: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd4) begin
						step_q  <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/metrohash64_stream_hasher.sv =====
`default_nettype none
// One word at a time through a shared 64x32 multiplier; the sequencer sets the pace.
// Each word runs all its steps before the next is taken. Bulk word: one lane update; a word
// closing the last 32-byte group adds the lane fold. Tail words: held half, pair, or one mix
// per chunk; a word past the length goes straight to the end, and a first word adds seeding.
// Last word adds the finalizer; out_valid rises as the block returns to idle, and a
// result held by out_stall holds the next last word. Async active-low reset: idle, hash state
// zero, seed back to its default, no result pending.

module metrohash64_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] data_word,
	input  logic [3:0]  valid_bytes,
	input  logic [31:0] message_length,
	input  logic        first_word,
	input  logic        last_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] hash_value,
	input  logic        hash_seed_we,
	input  logic [31:0] hash_seed
);
	import mh64_pkg::*;

	mh_cmd_t cmd;

	// Control: beat bookkeeping and step sequencing
	mh64_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.message_length (message_length),
		.first_word     (first_word),
		.last_word      (last_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cmd            (cmd)
	);

	// Hash state, multiplier and result register
	mh64_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.data_word      (data_word),
		.message_length (message_length),
		.seed_we        (hash_seed_we),
		.seed_wdata     (hash_seed),
		.hash_value     (hash_value)
	);

endmodule

`default_nettype wire

// ===== hdl/mh64_checker.sv =====
`default_nettype none

module mh64_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] hash_value
);

	// An accepted beat is always followed by a stalled input
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accepted beat");

	// A new result appears only at the end of a busy stretch
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while idle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hash_value))
		else $error("result changed while stalled");

endmodule

bind metrohash64_stream_hasher mh64_checker u_mh64_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hash_value (hash_value)
);

`default_nettype wire
